// ===== design/sm83_alu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_alu_pkg
// Shared types and constants of the 8-bit ALU with flags: opcode codes,
// request and response payloads, decimal adjust constants.
// ----------------------------------------------------------------------------
package sm83_alu_pkg;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBC  = 5'd3,
      OP_AND  = 5'd4,
      OP_XOR  = 5'd5,
      OP_OR   = 5'd6,
      OP_CP   = 5'd7,
      OP_RLC  = 5'd8,
      OP_RRC  = 5'd9,
      OP_RL   = 5'd10,
      OP_RR   = 5'd11,
      OP_SLA  = 5'd12,
      OP_SRA  = 5'd13,
      OP_SWAP = 5'd14,
      OP_SRL  = 5'd15,
      OP_BIT  = 5'd16,
      OP_RES  = 5'd17,
      OP_SET  = 5'd18,
      OP_DAA  = 5'd19,
      OP_CPL  = 5'd20,
      OP_SCF  = 5'd21,
      OP_CCF  = 5'd22,
      OP_INC  = 5'd23,
      OP_DEC  = 5'd24
   } opcode_type;

   // decimal adjust
   localparam logic [7:0] DAA_BYTE_MAX  = 8'h99;
   localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;
   localparam logic [7:0] DAA_CORR_HI   = 8'h60;
   localparam logic [7:0] DAA_CORR_LO   = 8'h06;

   typedef struct packed {
      logic [4:0] opcode;
      logic [7:0] acc;
      logic [7:0] operand;
      logic [2:0] bit_index;
      logic       zero_in;
      logic       subtract_in;
      logic       half_carry_in;
      logic       carry_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic       zero_out;
      logic       subtract_out;
      logic       half_carry_out;
      logic       carry_out;
   } rsp_type;

endpackage

// ===== design/sm83_alu_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_alu_unit
// Combinational datapath: one request in, result byte and new flags out.
// ----------------------------------------------------------------------------
module sm83_alu_unit
   import sm83_alu_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [7:0] a;
   logic [7:0] v;
   logic       cin;
   logic [8:0] add_sum;
   logic [4:0] add_half;
   logic [8:0] sub_diff;
   logic [4:0] sub_half;
   logic [7:0] bit_mask;
   logic [7:0] daa_corr;
   logic       daa_carry;
   logic [7:0] res;
   logic       z;
   logic       n;
   logic       h;
   logic       c;
   logic       set_zero;

   assign a = req.acc;
   assign v = req.operand;

   // carry or borrow in only for the with-carry forms
   assign cin = ((req.opcode == OP_ADC) || (req.opcode == OP_SBC)) ? req.carry_in : 1'b0;

   assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, cin};
   assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
   assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, cin};
   assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

   assign bit_mask = 8'd1 << req.bit_index;

   always_comb begin
      daa_corr  = 8'd0;
      daa_carry = req.carry_in;
      if (req.half_carry_in || (!req.subtract_in && (a[3:0] > DAA_DIGIT_MAX))) begin
         daa_corr = daa_corr | DAA_CORR_LO;
      end
      if (req.carry_in || (!req.subtract_in && (a > DAA_BYTE_MAX))) begin
         daa_corr  = daa_corr | DAA_CORR_HI;
         daa_carry = 1'b1;
      end
   end

   always_comb begin
      res      = a;
      z        = req.zero_in;
      n        = req.subtract_in;
      h        = req.half_carry_in;
      c        = req.carry_in;
      set_zero = 1'b1;
      unique case (req.opcode)
         OP_ADD, OP_ADC: begin
            res = add_sum[7:0];
            c   = add_sum[8];
            h   = add_half[4];
            n   = 1'b0;
         end
         OP_SUB, OP_SBC: begin
            res = sub_diff[7:0];
            c   = sub_diff[8];
            h   = sub_half[4];
            n   = 1'b1;
         end
         OP_CP: begin
            // flags as for subtract, accumulator returned unchanged
            z        = (sub_diff[7:0] == 8'd0);
            c        = sub_diff[8];
            h        = sub_half[4];
            n        = 1'b1;
            set_zero = 1'b0;
         end
         OP_AND: begin res = a & v; n = 1'b0; h = 1'b1; c = 1'b0; end
         OP_XOR: begin res = a ^ v; n = 1'b0; h = 1'b0; c = 1'b0; end
         OP_OR:  begin res = a | v; n = 1'b0; h = 1'b0; c = 1'b0; end
         OP_RLC: begin res = {v[6:0], v[7]};            c = v[7]; n = 1'b0; h = 1'b0; end
         OP_RRC: begin res = {v[0], v[7:1]};            c = v[0]; n = 1'b0; h = 1'b0; end
         OP_RL:  begin res = {v[6:0], req.carry_in};    c = v[7]; n = 1'b0; h = 1'b0; end
         OP_RR:  begin res = {req.carry_in, v[7:1]};    c = v[0]; n = 1'b0; h = 1'b0; end
         OP_SLA: begin res = {v[6:0], 1'b0};            c = v[7]; n = 1'b0; h = 1'b0; end
         OP_SRA: begin res = {v[7], v[7:1]};            c = v[0]; n = 1'b0; h = 1'b0; end
         OP_SWAP: begin res = {v[3:0], v[7:4]};         c = 1'b0; n = 1'b0; h = 1'b0; end
         OP_SRL: begin res = {1'b0, v[7:1]};            c = v[0]; n = 1'b0; h = 1'b0; end
         OP_BIT: begin
            res      = v;
            z        = ~v[req.bit_index];
            n        = 1'b0;
            h        = 1'b1;
            set_zero = 1'b0;
         end
         OP_RES: begin res = v & ~bit_mask; set_zero = 1'b0; end
         OP_SET: begin res = v | bit_mask;  set_zero = 1'b0; end
         OP_DAA: begin
            res = req.subtract_in ? (a - daa_corr) : (a + daa_corr);
            c   = daa_carry;
            h   = 1'b0;
         end
         OP_CPL: begin res = ~a; n = 1'b1; h = 1'b1; set_zero = 1'b0; end
         OP_SCF: begin n = 1'b0; h = 1'b0; c = 1'b1;  set_zero = 1'b0; end
         OP_CCF: begin n = 1'b0; h = 1'b0; c = ~req.carry_in; set_zero = 1'b0; end
         OP_INC: begin
            res = v + 8'd1;
            h   = (v[3:0] == 4'hF);
            n   = 1'b0;
         end
         OP_DEC: begin
            res = v - 8'd1;
            h   = (v[3:0] == 4'h0);
            n   = 1'b1;
         end
         default: begin
            // unused codes pass everything through
            set_zero = 1'b0;
         end
      endcase
      if (set_zero) begin
         z = (res == 8'd0);
      end
   end

   assign rsp.result         = res;
   assign rsp.zero_out       = z;
   assign rsp.subtract_out   = n;
   assign rsp.half_carry_out = h;
   assign rsp.carry_out      = c;

endmodule

// ===== design/cpu_alu_with_flags_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_core
// 8-bit processor ALU with Z/N/H/C flags, registered in and out.
// ----------------------------------------------------------------------------
// usage
//  - request channel: drive req_data and raise start; a request is taken at
//    each rising edge where start is high and busy is low
//  - busy is only high while reset is asserted, so outside reset a request
//    can be issued every cycle
//  - response channel: rsp_strobe is high for exactly one cycle with the
//    result byte and the four new flags on rsp_data
//  - pipeline: request register then response register, with the
//    whole ALU operation done in the single logic stage between them
//  - throughput: one request per cycle outside reset, set by that single ALU stage
//  - the receiver has no way to stall; each response must be taken in its
//    strobe cycle, which keeps the pipeline free running
//  - reset (synchronous, active high) empties both stages, so no strobe
//    follows a request that was in flight when reset arrived
//  - responses come out in request order, one per request
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_core
   import sm83_alu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // request stage
   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;

   // response stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // no back pressure, only hold off while in reset
   assign busy = reset;

   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // payload registers load only on a live request
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // the whole operation in one pass
   sm83_alu_unit u_unit (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/sm83_alu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_alu_checker
// Port level checks of the ALU core, bound to the top level.
// ----------------------------------------------------------------------------
module sm83_alu_checker
   import sm83_alu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic req_take;

   assign req_take = start && !busy;

   // every request gives a response through the request and response registers
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> ##1 rsp_strobe)
      else $error("missing response for request");

   // no response without a request taken into the request register before it
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_take, 2))
      else $error("response without request");

   // compare returns the accumulator unchanged
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.opcode == OP_CP)) |=> ##1
         (rsp_data.result == $past(req_data.acc, 2)))
      else $error("compare altered the accumulator");

   // set carry flag forces carry and clears subtract and half carry
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.opcode == OP_SCF)) |=> ##1
         (rsp_data.carry_out && !rsp_data.subtract_out && !rsp_data.half_carry_out))
      else $error("wrong flags after set carry");

endmodule

bind cpu_alu_with_flags_core sm83_alu_checker u_checker (.*);
